@@ src/ibt_pkg.sv @@
`timescale 1ns / 1ps

package ibt_pkg;

  // Table geometry
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W     = $clog2(DEPTH);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_ROTATE
  } state_e;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } op_e;

  typedef enum logic [1:0] {
    STAT_ENTRY    = 2'd0,
    STAT_CONFLICT = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_INVALID  = 2'd3
  } status_e;

  // One stored interval [st, en)
  typedef struct packed {
    time_t st;
    time_t en;
  } slot_t;

  // Control broadcast from the sequencer to the cells
  typedef struct packed {
    op_e   op;
    logic  merge_prev;
    logic  merge_next;
    time_t s;
    time_t f;
  } cell_ctrl_t;

  // Per-cell compare results returned to neighbors and to the sequencer
  typedef struct packed {
    logic lt;          // stored interval starts after the request
    logic at;          // lt, or cell is empty
    logic conf;        // stored interval overlaps the request
    logic touch_prev;  // stored finish equals request start
    logic touch_next;  // stored start equals request finish
  } cell_flags_t;

endpackage

@@ src/ibt_cell.sv @@
`timescale 1ns / 1ps

module ibt_cell (
  input  logic                 clk_i,
  input  ibt_pkg::cell_ctrl_t  ctl_i,
  input  logic                 vld_i,
  input  ibt_pkg::slot_t       left_i,
  input  logic                 left_lt_i,
  input  logic                 left_at_i,
  input  ibt_pkg::slot_t       right_i,
  output ibt_pkg::slot_t       slot_o,
  output ibt_pkg::cell_flags_t flags_o
);

  ibt_pkg::slot_t slot_q, slot_d;
  logic           lt, at, conf, touch_prev, touch_next;

  // Local compares against the request
  assign lt         = vld_i && (ctl_i.s < slot_q.st);
  assign at         = lt || !vld_i;
  assign conf       = vld_i && (ctl_i.s < slot_q.en) && (slot_q.st < ctl_i.f);
  assign touch_prev = vld_i && (slot_q.en == ctl_i.s);
  assign touch_next = vld_i && (slot_q.st == ctl_i.f);

  assign flags_o.lt         = lt;
  assign flags_o.at         = at;
  assign flags_o.conf       = conf;
  assign flags_o.touch_prev = touch_prev;
  assign flags_o.touch_next = touch_next;
  assign slot_o             = slot_q;

  // Next content: insert with neighbor merge, or rotate toward cell 0
  always_comb begin
    slot_d = slot_q;
    case (ctl_i.op)
      ibt_pkg::OP_ROTATE: begin
        slot_d = right_i;
      end
      ibt_pkg::OP_INSERT: begin
        if (ctl_i.merge_prev && ctl_i.merge_next) begin
          // bridge: predecessor absorbs successor, tail closes the gap
          if (touch_prev) begin
            slot_d.en = right_i.en;
          end else if (lt) begin
            slot_d = right_i;
          end
        end else if (ctl_i.merge_prev) begin
          if (touch_prev) begin
            slot_d.en = ctl_i.f;
          end
        end else if (ctl_i.merge_next) begin
          if (touch_next) begin
            slot_d.st = ctl_i.s;
          end
        end else begin
          // plain insert: open a gap at the first later or empty cell
          if (left_lt_i) begin
            slot_d = left_i;
          end else if (at && !left_at_i) begin
            slot_d.st = ctl_i.s;
            slot_d.en = ctl_i.f;
          end
        end
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

@@ src/ibt_ctrl.sv @@
`timescale 1ns / 1ps

module ibt_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ibt_pkg::TIME_BITS-1:0]        req_start_i,
  input  logic [ibt_pkg::TIME_BITS-1:0]        req_finish_i,
  input  logic [ibt_pkg::DEPTH-1:0]            conf_i,
  input  logic [ibt_pkg::DEPTH-1:0]            touch_prev_i,
  input  logic [ibt_pkg::DEPTH-1:0]            touch_next_i,
  input  ibt_pkg::slot_t                       head_i,
  output ibt_pkg::cell_ctrl_t                  ctl_o,
  output logic [ibt_pkg::DEPTH-1:0]            vld_o,
  output logic                                 result_valid_o,
  output logic [1:0]                           status_o,
  output logic [ibt_pkg::TIME_BITS-1:0]        slot_start_o,
  output logic [ibt_pkg::TIME_BITS-1:0]        slot_finish_o,
  output logic                                 last_o
);

  localparam int unsigned CW = ibt_pkg::CNT_W;
  localparam int unsigned IW = ibt_pkg::IDX_W;

  ibt_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    rot_q, rot_d;
  ibt_pkg::time_t   req_s_q, req_f_q;
  logic             out_vld_q, out_vld_d;
  ibt_pkg::status_e out_stat_q, out_stat_d;
  ibt_pkg::slot_t   out_slot_q, out_slot_d;
  logic             out_last_q, out_last_d;

  logic             accept, invalid, conflict, full, err;
  logic             merge_prev, merge_next, rot_end, emit;
  ibt_pkg::status_e err_stat;
  ibt_pkg::op_e     op;

  // Request checks against the whole chain
  assign invalid    = req_s_q >= req_f_q;
  assign conflict   = |conf_i;
  assign full       = cnt_q == CW'(ibt_pkg::DEPTH);
  assign err        = invalid || conflict || full;
  assign merge_prev = |touch_prev_i;
  assign merge_next = |touch_next_i;
  assign rot_end    = rot_q == IW'(ibt_pkg::DEPTH - 1);
  assign emit       = CW'(rot_q) < cnt_q;
  assign accept     = start && !busy;

  always_comb begin
    if (invalid) begin
      err_stat = ibt_pkg::STAT_INVALID;
    end else if (conflict) begin
      err_stat = ibt_pkg::STAT_CONFLICT;
    end else begin
      err_stat = ibt_pkg::STAT_FULL;
    end
  end

  // Occupancy decode for the cells
  always_comb begin
    for (int unsigned i = 0; i < ibt_pkg::DEPTH; i++) begin
      vld_o[i] = CW'(i) < cnt_q;
    end
  end

  assign ctl_o = '{op:         op,
                   merge_prev: merge_prev,
                   merge_next: merge_next,
                   s:          req_s_q,
                   f:          req_f_q};

  // Sequencer: check and insert in ST_INSERT, then rotate the whole ring unless the request is rejected
  always_comb begin
    state_d    = state_q;
    op         = ibt_pkg::OP_HOLD;
    busy       = 1'b1;
    cnt_d      = cnt_q;
    rot_d      = rot_q;
    out_vld_d  = 1'b0;
    out_stat_d = out_stat_q;
    out_slot_d = out_slot_q;
    out_last_d = out_last_q;
    case (state_q)
      ibt_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_d = ibt_pkg::ST_INSERT;
        end
      end
      ibt_pkg::ST_INSERT: begin
        rot_d = '0;
        if (err) begin
          state_d    = ibt_pkg::ST_IDLE;
          out_vld_d  = 1'b1;
          out_stat_d = err_stat;
          out_slot_d = '0;
          out_last_d = 1'b1;
        end else begin
          state_d = ibt_pkg::ST_ROTATE;
          op      = ibt_pkg::OP_INSERT;
          if (merge_prev && merge_next) begin
            cnt_d = cnt_q - CW'(1);
          end else if (!merge_prev && !merge_next) begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      ibt_pkg::ST_ROTATE: begin
        op    = ibt_pkg::OP_ROTATE;
        busy  = !rot_end;
        rot_d = rot_end ? '0 : rot_q + IW'(1);
        if (emit) begin
          out_vld_d  = 1'b1;
          out_stat_d = ibt_pkg::STAT_ENTRY;
          out_slot_d = head_i;
          out_last_d = (CW'(rot_q) + CW'(1)) == cnt_q;
        end
        if (rot_end) begin
          state_d = start ? ibt_pkg::ST_INSERT : ibt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ibt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ibt_pkg::ST_IDLE;
      cnt_q     <= '0;
      rot_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rot_q     <= rot_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_s_q <= req_start_i;
      req_f_q <= req_finish_i;
    end
    out_stat_q <= out_stat_d;
    out_slot_q <= out_slot_d;
    out_last_q <= out_last_d;
  end

  assign result_valid_o = out_vld_q;
  assign status_o       = 2'(out_stat_q);
  assign slot_start_o   = out_slot_q.st;
  assign slot_finish_o  = out_slot_q.en;
  assign last_o         = out_last_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ibt_pkg::DEPTH))
    else $error("entry count beyond table depth");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stat_q != ibt_pkg::STAT_ENTRY) |-> out_last_q)
    else $error("rejection not marked last");

  a_entry_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stat_q == ibt_pkg::STAT_ENTRY) |-> (cnt_q != '0))
    else $error("table entry emitted from empty table");

  a_insert_to_rotate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ibt_pkg::ST_INSERT && !err) |=>
      (state_q == ibt_pkg::ST_ROTATE && rot_q == '0))
    else $error("insert not followed by rotation pass");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ibt_pkg::ST_INSERT) |=> (cnt_q == $past(cnt_q)))
    else $error("entry count changed outside insert");
`endif

endmodule

@@ src/interval_booking_table.sv @@
`timescale 1ns / 1ps

// Interval booking table: keeps up to sixteen disjoint, start-sorted, half-open
// intervals in a chain of cells.
// Request channel: a transaction is taken at a rising edge with start high
// and busy low; req_start_i / req_finish_i are sampled at that edge.
// Result channel: result_valid_o marks each result for exactly one cycle;
// status_o, slot_start_o, slot_finish_o and last_o are valid with it. The
// receiver cannot stall, so results are never held.
// Timing: the cycle after acceptance compares the request against every cell
// and inserts/merges in place. A rejected request (invalid, conflict, full)
// gives one result in the next cycle; busy drops in that same cycle. A
// successful request then rotates the cell ring once around, emitting one
// stored interval per cycle while the index is below the new count; busy
// drops in the last rotation cycle, where the next request can be accepted,
// so the ring rotation sets the spacing between successful requests.
// Reset clears the entry count and the sequencer; cell contents are not
// reset and are never read before they are written.

module interval_booking_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ibt_pkg::TIME_BITS-1:0] req_start_i,
  input  logic [ibt_pkg::TIME_BITS-1:0] req_finish_i,
  output logic                          result_valid_o,
  output logic [1:0]                    status_o,
  output logic [ibt_pkg::TIME_BITS-1:0] slot_start_o,
  output logic [ibt_pkg::TIME_BITS-1:0] slot_finish_o,
  output logic                          last_o
);

  localparam int unsigned D = ibt_pkg::DEPTH;

  ibt_pkg::cell_ctrl_t  ctl;
  logic [D-1:0]         vld;
  ibt_pkg::slot_t       slots [D];
  ibt_pkg::cell_flags_t flags [D];
  logic [D-1:0]         conf, touch_prev, touch_next;

  // Sequencer, count and result registers
  ibt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_start_i    (req_start_i),
    .req_finish_i   (req_finish_i),
    .conf_i         (conf),
    .touch_prev_i   (touch_prev),
    .touch_next_i   (touch_next),
    .head_i         (slots[0]),
    .ctl_o          (ctl),
    .vld_o          (vld),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .slot_start_o   (slot_start_o),
    .slot_finish_o  (slot_finish_o),
    .last_o         (last_o)
  );

  // Cell chain; the tail wraps to the head for rotation
  for (genvar i = 0; i < D; i++) begin : g_cell
    ibt_pkg::slot_t left, right;
    logic           left_lt, left_at;

    if (i == 0) begin : g_head
      assign left    = '0;
      assign left_lt = 1'b0;
      assign left_at = 1'b0;
    end else begin : g_body
      assign left    = slots[i-1];
      assign left_lt = flags[i-1].lt;
      assign left_at = flags[i-1].at;
    end

    if (i == D - 1) begin : g_tail
      assign right = slots[0];
    end else begin : g_mid
      assign right = slots[i+1];
    end

    ibt_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .vld_i     (vld[i]),
      .left_i    (left),
      .left_lt_i (left_lt),
      .left_at_i (left_at),
      .right_i   (right),
      .slot_o    (slots[i]),
      .flags_o   (flags[i])
    );

    assign conf[i]       = flags[i].conf;
    assign touch_prev[i] = flags[i].touch_prev;
    assign touch_next[i] = flags[i].touch_next;
  end

endmodule
